### rtl/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
package bsm_pkg;

    localparam int PRG_OFFSET_BITS = 21;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 9;
    localparam int MIRR_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CMD_W-1:0] CMD_CPU_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCANLINE_END  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PRG_TRANSLATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHR_TRANSLATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INIT          = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_FROM_PRG  = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_DECODE_MASK = 16'he001;
    localparam logic [ADDR_W-1:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] ADDR_MIRRORING   = 16'ha000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH   = 16'hc000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD  = 16'hc001;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE = 16'he000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE  = 16'he001;

    localparam logic [MIRR_W-1:0] MIRROR_VERT     = 2'd0;
    localparam logic [MIRR_W-1:0] MIRROR_HORZ     = 2'd1;
    localparam logic [MIRR_W-1:0] MIRROR_ONE_HIGH = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [LINE_W-1:0] scanline;
        logic              screen_visible;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic                       irq;
        logic [MIRR_W-1:0]          mirroring;
        logic [PRG_OFFSET_BITS-1:0] rom_offset;
    } result_t;

endpackage

### rtl/bsm_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface bsm_in_if;
    import bsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [LINE_W-1:0] scanline;
    logic              screen_visible;

    modport source (output valid, command, address, data, scanline, screen_visible,
                    input ready);
    modport sink   (input valid, command, address, data, scanline, screen_visible,
                    output ready);
endinterface

interface bsm_out_if;
    import bsm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       irq;
    logic [MIRR_W-1:0]          mirroring;
    logic [PRG_OFFSET_BITS-1:0] rom_offset;

    modport source (output valid, irq, mirroring, rom_offset, input ready);
    modport sink   (input valid, irq, mirroring, rom_offset, output ready);
endinterface

interface bsm_cfg_if;
    import bsm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bsm_in_reg.sv
// Input register: captures one beat and holds it until the core consumes it.
module bsm_in_reg
    import bsm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bsm_in_if.sink in_ch,
    input  logic   advance,
    output stage_t stage
);

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    assign in_ch.ready = !valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command        <= in_ch.command;
            item_reg.address        <= in_ch.address;
            item_reg.data           <= in_ch.data;
            item_reg.scanline       <= in_ch.scanline;
            item_reg.screen_visible <= in_ch.screen_visible;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

### rtl/bsm_core.sv
// Mapper state, config registers and the single-pass update / translate logic.
module bsm_core
    import bsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    bsm_cfg_if.sink cfg_ch,
    input  stage_t  stage,
    input  logic    advance,
    output result_t result
);

    localparam int CNT_W = 10;
    localparam logic [4:0] PRG_LOG2_MIN = 5'd15;
    localparam logic [4:0] PRG_LOG2_MAX = 5'(PRG_OFFSET_BITS);
    localparam logic [4:0] CHR_LOG2_MIN = 5'd10;
    localparam logic [4:0] CHR_LOG2_MAX = 5'd18;
    localparam logic [4:0] BANK8K_LOG2  = 5'd13;
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 9'd240;

    typedef logic [7:0] bank_arr8_t [8];
    typedef logic [7:0] bank_arr4_t [4];

    // config
    logic [4:0] prg_size_log2_reg;
    logic [4:0] chr_size_log2_reg;
    logic       chr_from_prg_reg;

    // mapper state
    logic [7:0]              bank_select_reg, bank_select_next;
    bank_arr8_t              bank_values_reg, bank_values_next;
    bank_arr4_t              prg_bank_reg, prg_bank_next;
    bank_arr8_t              chr_bank_reg, chr_bank_next;
    logic signed [CNT_W-1:0] irq_count_reg, irq_count_next;
    logic [7:0]              irq_reload_reg, irq_reload_next;
    logic                    irq_enable_reg, irq_enable_next;
    logic                    irq_armed_reg, irq_armed_next;
    logic                    reload_latch_reg, reload_latch_next;
    logic [MIRR_W-1:0]       mirror_reg, mirror_next;

    logic       fire;
    item_t      it;
    logic [4:0] prg_bits;
    logic [4:0] chr_bits;
    logic [8:0] prg_banks;
    logic [7:0] last_bank;
    logic [7:0] second_last;
    logic [PRG_OFFSET_BITS-1:0] prg_mask;
    logic [PRG_OFFSET_BITS-1:0] chr_mask;
    logic [2:0] bank_reg_idx;
    logic [2:0] chr_pair_idx;
    logic [2:0] chr_one_idx;
    logic signed [CNT_W-1:0] count_dec;
    logic [1:0] prg_win;
    logic [2:0] chr_win;
    logic [7:0] even_bank;

    function automatic bank_arr8_t chr_from_values(input bank_arr8_t vals, input logic inv);
        bank_arr8_t m;
        for (int i = 0; i < 2; i++)
        begin
            m[3'(2*i) ^ {inv, 2'b00}]       = {vals[i][7:1], 1'b0};
            m[3'(2*i + 1) ^ {inv, 2'b00}]   = {vals[i][7:1], 1'b1};
        end
        for (int i = 2; i < 6; i++)
        begin
            m[3'(i + 2) ^ {inv, 2'b00}] = vals[i];
        end
        return m;
    endfunction

    assign it   = stage.item;
    assign fire = stage.valid && advance;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_size_log2_reg <= PRG_LOG2_MIN;
            chr_size_log2_reg <= 5'd13;
            chr_from_prg_reg  <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_PRG_SIZE_LOG2: prg_size_log2_reg <= cfg_ch.data;
                CFG_CHR_SIZE_LOG2: chr_size_log2_reg <= cfg_ch.data;
                CFG_CHR_FROM_PRG:  chr_from_prg_reg  <= cfg_ch.data[0];
                default:           ;
            endcase
        end
    end

    // sizes and masks
    always_comb
    begin
        prg_bits = prg_size_log2_reg;
        if (prg_bits < PRG_LOG2_MIN) prg_bits = PRG_LOG2_MIN;
        if (prg_bits > PRG_LOG2_MAX) prg_bits = PRG_LOG2_MAX;
        chr_bits = chr_size_log2_reg;
        if (chr_bits < CHR_LOG2_MIN) chr_bits = CHR_LOG2_MIN;
        if (chr_bits > CHR_LOG2_MAX) chr_bits = CHR_LOG2_MAX;
        if (chr_from_prg_reg) chr_bits = prg_bits;
    end

    assign prg_banks   = 9'd1 << (prg_bits - BANK8K_LOG2);
    assign last_bank   = 8'(prg_banks - 9'd1);
    assign second_last = 8'(prg_banks - 9'd2);
    assign prg_mask    = PRG_OFFSET_BITS'(({1'b0, {PRG_OFFSET_BITS{1'b0}}} | (22'd1 << prg_bits))
                                          - 22'd1);
    assign chr_mask    = PRG_OFFSET_BITS'((22'd1 << chr_bits) - 22'd1);

    assign bank_reg_idx = bank_select_reg[2:0];
    assign chr_pair_idx = {bank_select_reg[7], bank_reg_idx[0], 1'b0};
    assign chr_one_idx  = 3'(bank_reg_idx + 3'd2) ^ {bank_select_reg[7], 2'b00};
    assign even_bank    = {it.data[7:1], 1'b0};
    assign prg_win      = it.address[14:13];
    assign chr_win      = it.address[12:10];

    // next state
    always_comb
    begin
        bank_select_next  = bank_select_reg;
        bank_values_next  = bank_values_reg;
        prg_bank_next     = prg_bank_reg;
        chr_bank_next     = chr_bank_reg;
        irq_count_next    = irq_count_reg;
        irq_reload_next   = irq_reload_reg;
        irq_enable_next   = irq_enable_reg;
        irq_armed_next    = irq_armed_reg;
        reload_latch_next = reload_latch_reg;
        mirror_next       = mirror_reg;
        count_dec         = irq_count_reg;
        result.irq        = 1'b0;
        result.rom_offset = '0;

        unique case (it.command)
            CMD_CPU_WRITE:
            begin
                unique case (it.address & ADDR_DECODE_MASK)
                    ADDR_BANK_SELECT:
                    begin
                        bank_select_next = it.data;
                        if (bank_select_reg[7] != it.data[7])
                        begin
                            chr_bank_next = chr_from_values(bank_values_reg, it.data[7]);
                        end
                        if (bank_select_reg[6] != it.data[6])
                        begin
                            prg_bank_next[it.data[6] ? 2 : 0] = bank_values_reg[6];
                            prg_bank_next[it.data[6] ? 0 : 2] = second_last;
                            prg_bank_next[1]                  = bank_values_reg[7];
                        end
                    end
                    ADDR_BANK_DATA:
                    begin
                        bank_values_next[bank_reg_idx] = it.data;
                        case (bank_reg_idx) inside
                            3'd0, 3'd1:
                            begin
                                chr_bank_next[chr_pair_idx]        = even_bank;
                                chr_bank_next[chr_pair_idx | 3'd1] = {it.data[7:1], 1'b1};
                            end
                            3'd2, 3'd3, 3'd4, 3'd5:
                            begin
                                chr_bank_next[chr_one_idx] = it.data;
                            end
                            3'd6:
                            begin
                                prg_bank_next[bank_select_reg[6] ? 2 : 0] = it.data;
                                prg_bank_next[bank_select_reg[6] ? 0 : 2] = second_last;
                            end
                            default:
                            begin
                                prg_bank_next[1]                          = it.data;
                                prg_bank_next[bank_select_reg[6] ? 0 : 2] = second_last;
                            end
                        endcase
                    end
                    ADDR_MIRRORING:
                    begin
                        mirror_next = it.data[6] ? MIRROR_ONE_HIGH :
                                      (it.data[0] ? MIRROR_HORZ : MIRROR_VERT);
                    end
                    ADDR_IRQ_LATCH:
                    begin
                        irq_reload_next = it.data;
                        if (reload_latch_reg)
                        begin
                            irq_count_next = CNT_W'(it.data);
                        end
                    end
                    ADDR_IRQ_RELOAD:
                    begin
                        reload_latch_next = 1'b1;
                        irq_count_next    = CNT_W'(it.data);
                    end
                    ADDR_IRQ_DISABLE:
                    begin
                        irq_enable_next = 1'b0;
                    end
                    ADDR_IRQ_ENABLE:
                    begin
                        irq_enable_next = 1'b1;
                        irq_armed_next  = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_SCANLINE_END:
            begin
                reload_latch_next = 1'b0;
                if (it.screen_visible && (it.scanline < VISIBLE_LINES))
                begin
                    count_dec = irq_count_reg - 10'sd1;
                end
                irq_count_next = count_dec;
                if (count_dec <= 10'sd0)
                begin
                    if (irq_enable_reg && irq_armed_reg)
                    begin
                        result.irq     = 1'b1;
                        irq_armed_next = 1'b0;
                    end
                    reload_latch_next = 1'b1;
                    irq_count_next    = CNT_W'(irq_reload_reg);
                end
            end
            CMD_PRG_TRANSLATE:
            begin
                if (it.address[15])
                begin
                    result.rom_offset = {prg_bank_reg[prg_win], it.address[12:0]} & prg_mask;
                end
            end
            CMD_CHR_TRANSLATE:
            begin
                if (it.address[15:13] == 3'd0)
                begin
                    result.rom_offset = {3'd0, chr_bank_reg[chr_win], it.address[9:0]}
                                        & chr_mask;
                end
            end
            CMD_INIT:
            begin
                bank_select_next  = '0;
                for (int i = 0; i < 8; i++)
                begin
                    bank_values_next[i] = '0;
                    chr_bank_next[i]    = 8'(i);
                end
                irq_count_next    = '0;
                irq_reload_next   = '0;
                irq_enable_next   = 1'b0;
                irq_armed_next    = 1'b0;
                reload_latch_next = 1'b0;
                prg_bank_next[0]  = {7'd0, chr_from_prg_reg};
                prg_bank_next[1]  = 8'({7'd0, chr_from_prg_reg} + 8'd1);
                prg_bank_next[2]  = 8'(last_bank - 8'd1);
                prg_bank_next[3]  = last_bank;
            end
            default: ;
        endcase

        result.mirroring = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                bank_values_reg[i] <= '0;
                chr_bank_reg[i]    <= 8'(i);
            end
            for (int i = 0; i < 4; i++)
            begin
                prg_bank_reg[i] <= 8'(i);
            end
            irq_count_reg    <= '0;
            irq_reload_reg   <= '0;
            irq_enable_reg   <= 1'b0;
            irq_armed_reg    <= 1'b0;
            reload_latch_reg <= 1'b0;
            mirror_reg       <= MIRROR_VERT;
        end
        else if (fire)
        begin
            bank_select_reg  <= bank_select_next;
            bank_values_reg  <= bank_values_next;
            prg_bank_reg     <= prg_bank_next;
            chr_bank_reg     <= chr_bank_next;
            irq_count_reg    <= irq_count_next;
            irq_reload_reg   <= irq_reload_next;
            irq_enable_reg   <= irq_enable_next;
            irq_armed_reg    <= irq_armed_next;
            reload_latch_reg <= reload_latch_next;
            mirror_reg       <= mirror_next;
        end
    end

endmodule

### rtl/bsm_out_reg.sv
// Result register: holds one result beat until the sink takes it.
module bsm_out_reg
    import bsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     stage,
    input  result_t    result,
    output logic       advance,
    bsm_out_if.source  out_ch
);

    logic    valid_reg;
    result_t result_reg;

    assign advance = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.valid)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.irq        = result_reg.irq;
    assign out_ch.mirroring  = result_reg.mirroring;
    assign out_ch.rom_offset = result_reg.rom_offset;

endmodule

### rtl/bank_switch_mapper_with_scanline_irq_top.sv
// Top level of the bank switch mapper with scanline IRQ.
// Items pass through the input register and then the result register. Throughput:
// one item per cycle unless the sink stalls; the result register frees the input side
// when the sink takes a beat. Config writes take effect in the cycle after the write.
// Reset clears control and IRQ state, selects vertical mirroring, loads the default
// config and the default window mapping at once; no clearing pass.
module bank_switch_mapper_with_scanline_irq_top
    import bsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bsm_in_if.sink    in_ch,
    bsm_out_if.source out_ch,
    bsm_cfg_if.sink   cfg_ch
);

    stage_t  stage;
    result_t result;
    logic    advance;

    bsm_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .stage   (stage)
    );

    bsm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_ch  (cfg_ch),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    bsm_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .result  (result),
        .advance (advance),
        .out_ch  (out_ch)
    );

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && advance |=> out_ch.valid)
        else $error("staged item did not reach result register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty result register");

    a_mirror_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.mirroring != 2'd3)
        else $error("invalid mirroring code");

    a_irq_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.irq |-> out_ch.rom_offset == '0)
        else $error("irq beat carries a rom offset");

endmodule
